// ===== hw/rtl/ptbs_pkg.sv =====
package ptbs_pkg;

    // Bank geometry
    localparam int NUM_TIMERS = 16;
    localparam int MAX_FIRES  = 63;
    localparam int IDX_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int FIRE_W     = $clog2(MAX_FIRES + 1);

    // Field widths
    localparam int TIME_W     = 64;
    localparam int SLOT_W     = 4;
    localparam int SIDX_W     = 8;
    localparam int REQ_W      = 2;
    localparam int KIND_W     = 2;

    // Input tdata: period_ns, slot_index, advance_ns
    localparam int IN_TDATA_W   = 136;
    localparam int IN_PER_LSB   = 0;
    localparam int IN_IDX_LSB   = IN_PER_LSB + TIME_W;
    localparam int IN_ADV_LSB   = IN_IDX_LSB + SIDX_W;

    // Output tdata: slot, ok, event_time, overflow, zero fill
    localparam int OUT_FIELDS_W = SLOT_W + 1 + TIME_W + 1;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;
    localparam int OUT_OK_BIT   = SLOT_W;
    localparam int OUT_TIME_LSB = SLOT_W + 1;
    localparam int OUT_OVF_BIT  = OUT_TIME_LSB + TIME_W;

    typedef enum logic [REQ_W-1:0] {
        REQ_ADD     = 2'd0,
        REQ_REMOVE  = 2'd1,
        REQ_ADVANCE = 2'd2
    } req_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_ADD    = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_FIRE   = 2'd2,
        KIND_DONE   = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD,
        ST_REMOVE,
        ST_SCAN,
        ST_EVAL,
        ST_DECIDE,
        ST_FIRE,
        ST_DONE
    } state_t;

endpackage

// ===== hw/rtl/ptbs_ram.sv =====
module ptbs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/periodic_timer_bank_scheduler.sv =====
// Periodic timer bank with a 64-bit virtual clock and earliest-deadline firing.
//
// Request channel (s_*): one transaction carries one request. s_tuser holds
// the request type (add, remove, advance); s_tdata holds period, slot index
// and advance amount. A request type of 3 is dropped without any result.
// Result channel (m_*): add and remove give one reply. Advance gives one fire
// result per expired timer (in due-time order, lowest slot on ties) and a
// closing done result; m_tlast marks the final result of each request.
//
// Add and remove results are registered after acceptance. Advance scans the
// due-time memory in full before each fire and once more before the done
// result. The single read port of the due/period memories paces each scan:
// one slot is compared per cycle.
// One request is handled at a time; s_tready is high only while idle.
//
// Reset clears all active bits, the virtual clock and the result valid flag.
// Due/period memories are not cleared; a slot is always written before use.
// When the receiver stalls, the pending result holds in the output register
// and the sequencer waits before producing the next one.
module periodic_timer_bank_scheduler (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [135:0] s_tdata,  // period[63:0], slot_index[71:64], advance_ns[135:72]
    input  logic [1:0]   s_tuser,  // req_type[1:0]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [71:0]  m_tdata,  // slot[3:0], ok[4], event_time[68:5], overflow[69], zero[71:70]
    output logic [1:0]   m_tuser,  // result_kind[1:0]
    output logic         m_tlast
);

    localparam int IDX_W  = ptbs_pkg::IDX_W;
    localparam int TIME_W = ptbs_pkg::TIME_W;
    localparam int FIRE_W = ptbs_pkg::FIRE_W;
    localparam int SLOT_W = ptbs_pkg::SLOT_W;
    localparam int NT     = ptbs_pkg::NUM_TIMERS;

    // Control registers
    ptbs_pkg::state_t    state_reg, state_next;
    logic [NT-1:0]       active_reg, active_next;
    logic [TIME_W-1:0]   time_reg, time_next;
    logic [IDX_W-1:0]    scan_cnt_reg, scan_cnt_next;
    logic                cmp_vld_reg, cmp_vld_next;
    logic                best_vld_reg, best_vld_next;
    logic [FIRE_W-1:0]   fire_cnt_reg, fire_cnt_next;
    logic                ovf_reg, ovf_next;
    logic                m_valid_reg, m_valid_next;

    // Payload registers
    logic [TIME_W-1:0]   period_reg, period_next;
    logic [ptbs_pkg::SIDX_W-1:0] idx_reg, idx_next;
    logic [TIME_W-1:0]   target_reg, target_next;
    logic [IDX_W-1:0]    cmp_idx_reg, cmp_idx_next;
    logic [IDX_W-1:0]    best_idx_reg, best_idx_next;
    logic [TIME_W-1:0]   best_due_reg, best_due_next;
    logic [TIME_W-1:0]   best_per_reg, best_per_next;
    ptbs_pkg::kind_t     m_kind_reg, m_kind_next;
    logic [SLOT_W-1:0]   m_slot_reg, m_slot_next;
    logic                m_ok_reg, m_ok_next;
    logic [TIME_W-1:0]   m_time_reg, m_time_next;
    logic                m_ovf_reg, m_ovf_next;
    logic                m_last_reg, m_last_next;

    // Memory ports
    logic                due_we, per_we;
    logic [IDX_W-1:0]    waddr;
    logic [TIME_W-1:0]   due_wdata;
    logic [TIME_W-1:0]   due_rdata, per_rdata;

    // Lowest free slot
    logic                free_found;
    logic [IDX_W-1:0]    free_idx;
    logic                out_free;
    logic                s_acc;

    ptbs_ram #(
        .WIDTH (TIME_W),
        .DEPTH (NT)
    ) u_due_ram (
        .clk   (clk),
        .we    (due_we),
        .waddr (waddr),
        .wdata (due_wdata),
        .raddr (scan_cnt_reg),
        .rdata (due_rdata)
    );

    ptbs_ram #(
        .WIDTH (TIME_W),
        .DEPTH (NT)
    ) u_per_ram (
        .clk   (clk),
        .we    (per_we),
        .waddr (waddr),
        .wdata (period_reg),
        .raddr (scan_cnt_reg),
        .rdata (per_rdata)
    );

    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = NT - 1; i >= 0; i--)
        begin
            if (!active_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
        end
    end

    assign s_tready = (state_reg == ptbs_pkg::ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    // The result register may take a new transaction when empty or draining.
    assign out_free = !m_valid_reg || m_tready;

    always_comb
    begin
        state_next    = state_reg;
        active_next   = active_reg;
        time_next     = time_reg;
        scan_cnt_next = scan_cnt_reg;
        cmp_vld_next  = 1'b0;
        cmp_idx_next  = scan_cnt_reg;
        best_vld_next = best_vld_reg;
        best_idx_next = best_idx_reg;
        best_due_next = best_due_reg;
        best_per_next = best_per_reg;
        fire_cnt_next = fire_cnt_reg;
        ovf_next      = ovf_reg;
        period_next   = period_reg;
        idx_next      = idx_reg;
        target_next   = target_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_kind_next   = m_kind_reg;
        m_slot_next   = m_slot_reg;
        m_ok_next     = m_ok_reg;
        m_time_next   = m_time_reg;
        m_ovf_next    = m_ovf_reg;
        m_last_next   = m_last_reg;
        due_we        = 1'b0;
        per_we        = 1'b0;
        waddr         = free_idx;
        due_wdata     = time_reg + period_reg;

        // Fold the slot returned by the memories into the running minimum;
        // strict compare keeps the lowest slot on ties.
        if (cmp_vld_reg && active_reg[cmp_idx_reg] &&
            (!best_vld_reg || due_rdata < best_due_reg))
        begin
            best_vld_next = 1'b1;
            best_idx_next = cmp_idx_reg;
            best_due_next = due_rdata;
            best_per_next = per_rdata;
        end

        unique case (state_reg)
            ptbs_pkg::ST_IDLE:
            begin
                if (s_acc)
                begin
                    period_next   = s_tdata[ptbs_pkg::IN_PER_LSB +: TIME_W];
                    idx_next      = s_tdata[ptbs_pkg::IN_IDX_LSB +: ptbs_pkg::SIDX_W];
                    target_next   = time_reg + s_tdata[ptbs_pkg::IN_ADV_LSB +: TIME_W];
                    scan_cnt_next = '0;
                    best_vld_next = 1'b0;
                    fire_cnt_next = '0;
                    ovf_next      = 1'b0;
                    unique case (s_tuser)
                        ptbs_pkg::REQ_ADD:     state_next = ptbs_pkg::ST_ADD;
                        ptbs_pkg::REQ_REMOVE:  state_next = ptbs_pkg::ST_REMOVE;
                        ptbs_pkg::REQ_ADVANCE: state_next = ptbs_pkg::ST_SCAN;
                        default:               state_next = ptbs_pkg::ST_IDLE;
                    endcase
                end
            end

            ptbs_pkg::ST_ADD:
            begin
                if (out_free)
                begin
                    if (free_found)
                    begin
                        due_we                = 1'b1;
                        per_we                = 1'b1;
                        active_next[free_idx] = 1'b1;
                    end
                    m_valid_next = 1'b1;
                    m_kind_next  = ptbs_pkg::KIND_ADD;
                    m_slot_next  = SLOT_W'(free_idx);
                    m_ok_next    = free_found;
                    m_time_next  = '0;
                    m_ovf_next   = 1'b0;
                    m_last_next  = 1'b1;
                    state_next   = ptbs_pkg::ST_IDLE;
                end
            end

            ptbs_pkg::ST_REMOVE:
            begin
                if (out_free)
                begin
                    if (32'(idx_reg) < NT)
                    begin
                        active_next[idx_reg[IDX_W-1:0]] = 1'b0;
                    end
                    m_valid_next = 1'b1;
                    m_kind_next  = ptbs_pkg::KIND_REMOVE;
                    m_slot_next  = '0;
                    m_ok_next    = (32'(idx_reg) < NT);
                    m_time_next  = '0;
                    m_ovf_next   = 1'b0;
                    m_last_next  = 1'b1;
                    state_next   = ptbs_pkg::ST_IDLE;
                end
            end

            ptbs_pkg::ST_SCAN:
            begin
                // Issue one read per cycle; the data is compared in the cycle after.
                cmp_vld_next  = 1'b1;
                scan_cnt_next = scan_cnt_reg + 1'b1;
                if (scan_cnt_reg == IDX_W'(NT - 1))
                begin
                    scan_cnt_next = '0;
                    state_next    = ptbs_pkg::ST_EVAL;
                end
            end

            ptbs_pkg::ST_EVAL:
            begin
                state_next = ptbs_pkg::ST_DECIDE;
            end

            ptbs_pkg::ST_DECIDE:
            begin
                priority if (!best_vld_reg || best_due_reg > target_reg)
                begin
                    state_next = ptbs_pkg::ST_DONE;
                end
                else if (fire_cnt_reg == FIRE_W'(ptbs_pkg::MAX_FIRES))
                begin
                    ovf_next   = 1'b1;
                    state_next = ptbs_pkg::ST_DONE;
                end
                else
                begin
                    state_next = ptbs_pkg::ST_FIRE;
                end
            end

            ptbs_pkg::ST_FIRE:
            begin
                if (out_free)
                begin
                    // Re-arm the winner; the next scan starts after this write.
                    due_we        = 1'b1;
                    waddr         = best_idx_reg;
                    due_wdata     = best_due_reg + best_per_reg;
                    time_next     = best_due_reg;
                    fire_cnt_next = fire_cnt_reg + 1'b1;
                    best_vld_next = 1'b0;
                    scan_cnt_next = '0;
                    m_valid_next  = 1'b1;
                    m_kind_next   = ptbs_pkg::KIND_FIRE;
                    m_slot_next   = SLOT_W'(best_idx_reg);
                    m_ok_next     = 1'b0;
                    m_time_next   = best_due_reg;
                    m_ovf_next    = 1'b0;
                    m_last_next   = 1'b0;
                    state_next    = ptbs_pkg::ST_SCAN;
                end
            end

            ptbs_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    if (!ovf_reg)
                    begin
                        time_next = target_reg;
                    end
                    m_valid_next = 1'b1;
                    m_kind_next  = ptbs_pkg::KIND_DONE;
                    m_slot_next  = '0;
                    m_ok_next    = 1'b0;
                    m_time_next  = ovf_reg ? time_reg : target_reg;
                    m_ovf_next   = ovf_reg;
                    m_last_next  = 1'b1;
                    state_next   = ptbs_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = ptbs_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ptbs_pkg::ST_IDLE;
            active_reg   <= '0;
            time_reg     <= '0;
            scan_cnt_reg <= '0;
            cmp_vld_reg  <= 1'b0;
            best_vld_reg <= 1'b0;
            fire_cnt_reg <= '0;
            ovf_reg      <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            active_reg   <= active_next;
            time_reg     <= time_next;
            scan_cnt_reg <= scan_cnt_next;
            cmp_vld_reg  <= cmp_vld_next;
            best_vld_reg <= best_vld_next;
            fire_cnt_reg <= fire_cnt_next;
            ovf_reg      <= ovf_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        period_reg   <= period_next;
        idx_reg      <= idx_next;
        target_reg   <= target_next;
        cmp_idx_reg  <= cmp_idx_next;
        best_idx_reg <= best_idx_next;
        best_due_reg <= best_due_next;
        best_per_reg <= best_per_next;
        m_kind_reg   <= m_kind_next;
        m_slot_reg   <= m_slot_next;
        m_ok_reg     <= m_ok_next;
        m_time_reg   <= m_time_next;
        m_ovf_reg    <= m_ovf_next;
        m_last_reg   <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {ptbs_pkg::OUT_PAD_W'(0), m_ovf_reg, m_time_reg, m_ok_reg, m_slot_reg};

endmodule

// ===== hw/rtl/ptbs_checker.sv =====
module ptbs_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic [135:0] s_tdata,
    input logic [1:0]   s_tuser,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [71:0]  m_tdata,
    input logic [1:0]   m_tuser,
    input logic         m_tlast
);

    // Stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("result changed while stalled");

    // Add and remove replies close their request
    a_reply_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == ptbs_pkg::KIND_ADD || m_tuser == ptbs_pkg::KIND_REMOVE)
            |-> m_tlast && !m_tdata[ptbs_pkg::OUT_OVF_BIT])
        else $error("reply without last or with overflow");

    // Fire results never close a request and carry no ok flag
    a_fire_fields: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == ptbs_pkg::KIND_FIRE
            |-> !m_tlast && !m_tdata[ptbs_pkg::OUT_OK_BIT] && !m_tdata[ptbs_pkg::OUT_OVF_BIT])
        else $error("malformed fire result");

    // An accepted add, remove or advance request leaves the block busy in the next cycle
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == ptbs_pkg::REQ_ADD ||
            s_tuser == ptbs_pkg::REQ_REMOVE || s_tuser == ptbs_pkg::REQ_ADVANCE)
            |=> !s_tready)
        else $error("request accepted back to back");

endmodule

bind periodic_timer_bank_scheduler ptbs_checker u_ptbs_checker (.*);

// ===== tb/sv/periodic_timer_bank_scheduler_test.sv =====
`default_nettype none

module periodic_timer_bank_scheduler_test;

    timeunit 1ns;
    timeprecision 1ps;

    // Request code 3 has no meaning; the block drops it without a result.
    localparam logic [ptbs_pkg::REQ_W-1:0] REQ_UNKNOWN = 2'd3;
    localparam logic [ptbs_pkg::TIME_W-1:0] TIME_ALL_ONES = '1;
    // Settling time after the last result, waited out by drain_results.
    localparam int DRAIN_CYCLES = 2 * (ptbs_pkg::NUM_TIMERS + 2) + 8;

    // One result transaction, split into its fields.
    typedef struct packed {
        ptbs_pkg::kind_t                 kind;
        logic [ptbs_pkg::SLOT_W-1:0]     slot;
        logic                            ok;
        logic [ptbs_pkg::TIME_W-1:0]     evt_time;
        logic                            ovf;
        logic                            last;
        logic [ptbs_pkg::OUT_PAD_W-1:0]  pad;
    } sched_result_t;

    logic                              clk;
    logic                              rst_n;
    logic                              s_tvalid;
    logic                              s_tready;
    logic [ptbs_pkg::IN_TDATA_W-1:0]   s_tdata;   // period, slot_index, advance_ns (low to high)
    logic [ptbs_pkg::REQ_W-1:0]        s_tuser;   // req_type
    logic                              m_tvalid;
    logic                              m_tready;
    logic [ptbs_pkg::OUT_TDATA_W-1:0]  m_tdata;   // slot, ok, event_time, overflow, zero fill
    logic [ptbs_pkg::KIND_W-1:0]       m_tuser;   // result_kind
    logic                              m_tlast;

    // Shadow copy of the timer bank, kept in step with accepted requests.
    logic                          tmr_active [ptbs_pkg::NUM_TIMERS];
    logic [ptbs_pkg::TIME_W-1:0]   tmr_period [ptbs_pkg::NUM_TIMERS];
    logic [ptbs_pkg::TIME_W-1:0]   tmr_due    [ptbs_pkg::NUM_TIMERS];
    logic [ptbs_pkg::TIME_W-1:0]   virt_now;

    // Results still owed by the block, oldest first.
    sched_result_t           pending_results [$];
    sched_result_t           seen_result;
    sched_result_t           want_result;

    int                      mismatch_count;
    int                      src_idle_pct;
    int                      sink_idle_pct;

    periodic_timer_bank_scheduler dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Hard stop in case the block hangs somewhere.
    initial
    begin
        #20_000_000;
        $display("%0t ns: timeout, %0d results still outstanding", $time,
                 pending_results.size());
        $display("Test completed with failures");
        $finish;
    end

    // Receiver side: drop tready at random, at the rate of the current phase.
    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // Queue one expected result; unused bits of the result stay zero.
    function automatic void queue_result(ptbs_pkg::kind_t kind,
                                         logic [ptbs_pkg::SLOT_W-1:0] slot, logic ok,
                                         logic [ptbs_pkg::TIME_W-1:0] evt_time, logic ovf,
                                         logic last);
        sched_result_t r;
        r.kind     = kind;
        r.slot     = slot;
        r.ok       = ok;
        r.evt_time = evt_time;
        r.ovf      = ovf;
        r.last     = last;
        r.pad      = '0;
        pending_results.push_back(r);
    endfunction

    // Active slot with the lowest due time, lowest index on ties; -1 if none.
    function automatic int earliest_timer();
        int best;
        best = -1;
        for (int i = 0; i < ptbs_pkg::NUM_TIMERS; i++)
        begin
            if (tmr_active[i] && (best < 0 || tmr_due[i] < tmr_due[best]))
                best = i;
        end
        return best;
    endfunction

    // Advance the shadow bank by one accepted request and queue what it owes.
    task automatic apply_request(input logic [ptbs_pkg::REQ_W-1:0] rt,
                                 input logic [ptbs_pkg::TIME_W-1:0] per,
                                 input logic [ptbs_pkg::SIDX_W-1:0] idx,
                                 input logic [ptbs_pkg::TIME_W-1:0] adv);
        int                          free_slot;
        int                          pick;
        int                          fires;
        logic                        scanning;
        logic                        capped;
        logic [ptbs_pkg::TIME_W-1:0] target;
        free_slot = -1;
        case (rt)
            ptbs_pkg::REQ_ADD:
            begin
                for (int i = ptbs_pkg::NUM_TIMERS - 1; i >= 0; i--)
                begin
                    if (!tmr_active[i])
                        free_slot = i;
                end
                if (free_slot >= 0)
                begin
                    tmr_period[free_slot] = per;
                    tmr_due[free_slot]    = virt_now + per;
                    tmr_active[free_slot] = 1'b1;
                    queue_result(ptbs_pkg::KIND_ADD, ptbs_pkg::SLOT_W'(free_slot), 1'b1, '0,
                                 1'b0, 1'b1);
                end
                else
                begin
                    queue_result(ptbs_pkg::KIND_ADD, '0, 1'b0, '0, 1'b0, 1'b1);
                end
            end
            ptbs_pkg::REQ_REMOVE:
            begin
                if (idx < ptbs_pkg::NUM_TIMERS)
                begin
                    tmr_active[idx] = 1'b0;
                    queue_result(ptbs_pkg::KIND_REMOVE, '0, 1'b1, '0, 1'b0, 1'b1);
                end
                else
                begin
                    queue_result(ptbs_pkg::KIND_REMOVE, '0, 1'b0, '0, 1'b0, 1'b1);
                end
            end
            ptbs_pkg::REQ_ADVANCE:
            begin
                target   = virt_now + adv;
                fires    = 0;
                capped   = 1'b0;
                scanning = 1'b1;
                while (scanning)
                begin
                    pick = earliest_timer();
                    if (pick < 0 || tmr_due[pick] > target)
                    begin
                        scanning = 1'b0;
                    end
                    else if (fires >= ptbs_pkg::MAX_FIRES)
                    begin
                        // Hold the clock at the last fire: a timer is still due.
                        capped   = 1'b1;
                        scanning = 1'b0;
                    end
                    else
                    begin
                        virt_now      = tmr_due[pick];
                        tmr_due[pick] = tmr_due[pick] + tmr_period[pick];
                        queue_result(ptbs_pkg::KIND_FIRE, ptbs_pkg::SLOT_W'(pick), 1'b0,
                                     virt_now, 1'b0, 1'b0);
                        fires++;
                    end
                end
                if (!capped)
                    virt_now = target;
                queue_result(ptbs_pkg::KIND_DONE, '0, 1'b0, virt_now, capped, 1'b1);
            end
            default:
            begin
                // Unknown request: dropped, nothing owed.
            end
        endcase
    endtask

    // Send one request transaction. Leave tvalid high on return so a
    // back-to-back request needs no second assignment in the same step.
    task automatic send_request(input logic [ptbs_pkg::REQ_W-1:0] rt,
                                input logic [ptbs_pkg::TIME_W-1:0] per,
                                input logic [ptbs_pkg::SIDX_W-1:0] idx,
                                input logic [ptbs_pkg::TIME_W-1:0] adv);
        int gap;
        gap = ($urandom_range(99) < src_idle_pct) ? $urandom_range(1, 8) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= rt;
        s_tdata  <= {adv, idx, per};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        apply_request(rt, per, idx, adv);
    endtask

    // Lower tvalid and wait until every owed result has come back.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Remove replies at the range boundary, on an inactive slot, and an
    // advance with an empty bank.
    task automatic test_remove_range();
        send_request(ptbs_pkg::REQ_REMOVE, '1, 8'd15, '1);
        send_request(ptbs_pkg::REQ_REMOVE, '0, 8'(ptbs_pkg::NUM_TIMERS), '0);
        send_request(ptbs_pkg::REQ_REMOVE, '1, 8'd255, '1);
        send_request(ptbs_pkg::REQ_ADVANCE, '1, 8'd255, '0);
    endtask

    // A timer due at all ones must still be picked; the re-arm wraps below
    // the target, so the advance runs into the fire cap.
    task automatic test_all_ones_due();
        send_request(ptbs_pkg::REQ_ADD, TIME_ALL_ONES, 8'd0, '0);
        send_request(ptbs_pkg::REQ_ADVANCE, '0, 8'd0, TIME_ALL_ONES);
        send_request(ptbs_pkg::REQ_REMOVE, '0, 8'd0, '0);
    endtask

    // Zero period: the timer fires at the same time until the cap.
    task automatic test_zero_period();
        send_request(ptbs_pkg::REQ_ADD, '0, 8'd0, '0);
        send_request(ptbs_pkg::REQ_ADVANCE, '0, 8'd0, '0);
        send_request(ptbs_pkg::REQ_REMOVE, '0, 8'd0, '0);
    endtask

    // Fill every slot, reject one more add, then fire a mix of timers.
    task automatic test_full_bank();
        for (int i = 0; i < ptbs_pkg::NUM_TIMERS; i++)
            send_request(ptbs_pkg::REQ_ADD, ptbs_pkg::TIME_W'(i * 5 + 3), 8'($urandom),
                         {$urandom, $urandom});
        send_request(ptbs_pkg::REQ_ADD, 64'd1, 8'd0, '0);
        send_request(ptbs_pkg::REQ_ADVANCE, '0, 8'd0, 64'd40);
    endtask

    // Random mix, weighted toward adds, removes and modest advances so that
    // the bank keeps a varied population of timers.
    task automatic test_random_traffic(input int count);
        int                          sel;
        logic [ptbs_pkg::REQ_W-1:0]  rt;
        logic [ptbs_pkg::TIME_W-1:0] per;
        logic [ptbs_pkg::TIME_W-1:0] adv;
        logic [ptbs_pkg::SIDX_W-1:0] idx;
        for (int n = 0; n < count; n++)
        begin
            // Fill unused fields with noise; the block must ignore them.
            per = {$urandom, $urandom};
            adv = {$urandom, $urandom};
            idx = ptbs_pkg::SIDX_W'($urandom);
            sel = $urandom_range(99);
            if (sel < 36)
            begin
                rt  = ptbs_pkg::REQ_ADD;
                sel = $urandom_range(99);
                if (sel < 3)
                    per = '0;
                else if (sel < 78)
                    per = ptbs_pkg::TIME_W'($urandom_range(2000, 1));
                else if (sel < 88)
                    per = TIME_ALL_ONES - ptbs_pkg::TIME_W'($urandom_range(3000));
                // otherwise keep the full-range random period
            end
            else if (sel < 60)
            begin
                rt = ptbs_pkg::REQ_REMOVE;
                if ($urandom_range(9) != 0)
                    idx = ptbs_pkg::SIDX_W'($urandom_range(ptbs_pkg::NUM_TIMERS - 1));
            end
            else if (sel < 96)
            begin
                rt  = ptbs_pkg::REQ_ADVANCE;
                sel = $urandom_range(99);
                if (sel < 5)
                    adv = '0;
                else if (sel < 80)
                    adv = ptbs_pkg::TIME_W'($urandom_range(1500));
                else if (sel < 88)
                    adv = ptbs_pkg::TIME_W'($urandom_range(50000, 2000));
                else if (sel < 92)
                    adv = TIME_ALL_ONES;
                // otherwise keep the full-range random advance
            end
            else
            begin
                rt = REQ_UNKNOWN;
            end
            send_request(rt, per, idx, adv);
        end
    endtask

    // Check every result transaction against the oldest owed result.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            seen_result.kind     = ptbs_pkg::kind_t'(m_tuser);
            seen_result.slot     = m_tdata[ptbs_pkg::SLOT_W-1:0];
            seen_result.ok       = m_tdata[ptbs_pkg::OUT_OK_BIT];
            seen_result.evt_time = m_tdata[ptbs_pkg::OUT_TIME_LSB +: ptbs_pkg::TIME_W];
            seen_result.ovf      = m_tdata[ptbs_pkg::OUT_OVF_BIT];
            seen_result.last     = m_tlast;
            seen_result.pad      = m_tdata[ptbs_pkg::OUT_TDATA_W-1 -: ptbs_pkg::OUT_PAD_W];
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                $display("%0t ns: unexpected result, expected none, actual kind=%0d slot=%0d time=%h",
                         $time, seen_result.kind, seen_result.slot, seen_result.evt_time);
            end
            else
            begin
                want_result = pending_results.pop_front();
                if (seen_result !== want_result)
                begin
                    mismatch_count++;
                    $display("%0t ns: result mismatch", $time);
                    $display("  expected kind=%0d slot=%0d ok=%0d time=%h ovf=%0d last=%0d pad=%0d",
                             want_result.kind, want_result.slot, want_result.ok,
                             want_result.evt_time, want_result.ovf, want_result.last,
                             want_result.pad);
                    $display("  actual   kind=%0d slot=%0d ok=%0d time=%h ovf=%0d last=%0d pad=%0d",
                             seen_result.kind, seen_result.slot, seen_result.ok,
                             seen_result.evt_time, seen_result.ovf, seen_result.last,
                             seen_result.pad);
                end
            end
        end
    end

    initial
    begin
        mismatch_count = 0;
        src_idle_pct   = 15;
        sink_idle_pct  = 82;
        virt_now       = '0;
        for (int i = 0; i < ptbs_pkg::NUM_TIMERS; i++)
        begin
            tmr_active[i] = 1'b0;
            tmr_period[i] = '0;
            tmr_due[i]    = '0;
        end

        // Drive every input to a known value, then hold reset low before releasing it.
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        m_tready <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Phase one: sender mostly busy, receiver stalls often.
        test_remove_range();
        test_all_ones_due();
        test_zero_period();
        test_full_bank();
        test_random_traffic(100);
        drain_results();

        // Phase two: sender idles often, receiver mostly ready.
        src_idle_pct  = 82;
        sink_idle_pct = 15;
        test_random_traffic(100);
        drain_results();

        // Phase three: no idling on either side.
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        test_random_traffic(82);
        drain_results();

        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire
